// ----- hdl/tuacc_pkg.sv -----
`timescale 1ns / 1ps
package tuacc_pkg;

  // stored seconds width; the seconds arithmetic wraps in this many bits
  localparam int SEC_W    = 52;
  localparam int GSEC_W   = 52;
  localparam int MICRO_W  = 20;
  localparam int AMOUNT_W = 32;
  localparam int DELTA_W  = 64;

  localparam int IN_FIELD_W  = AMOUNT_W + GSEC_W + MICRO_W;
  localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int IN_USER_W   = 5;
  localparam int OUT_FIELD_W = SEC_W + MICRO_W + DELTA_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_USER_W  = 2;

  localparam logic [MICRO_W-1:0] USEC_PER_SEC  = 20'd1000000;
  localparam logic [MICRO_W-1:0] USEC_PER_MSEC = 20'd1000;

  // unit codes; six and seven convert to zero
  localparam logic [2:0] UNIT_USEC = 3'd0;
  localparam logic [2:0] UNIT_MSEC = 3'd1;
  localparam logic [2:0] UNIT_SEC  = 3'd2;
  localparam logic [2:0] UNIT_MIN  = 3'd3;
  localparam logic [2:0] UNIT_HOUR = 3'd4;
  localparam logic [2:0] UNIT_DAY  = 3'd5;

  // floor division by reciprocal: the amount is offset by a multiple of the
  // divisor to make it positive, then q ~ (u * floor(2^33 / d)) >> 33
  localparam int          RECIP_SHIFT = 33;
  localparam logic [23:0] RECIP_USEC  = 24'd8589;
  localparam logic [23:0] RECIP_MSEC  = 24'd8589934;
  localparam logic [32:0] OFF_USEC    = 33'd2148000000;
  localparam logic [32:0] OFF_MSEC    = 33'd2147484000;
  localparam logic [22:0] K_USEC      = 23'd2148;
  localparam logic [22:0] K_MSEC      = 23'd2147484;

  localparam logic [23:0] SEC_PER_SEC  = 24'd1;
  localparam logic [23:0] SEC_PER_MIN  = 24'd60;
  localparam logic [23:0] SEC_PER_HOUR = 24'd3600;
  localparam logic [23:0] SEC_PER_DAY  = 24'd86400;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_SUB   = 2'd2,
    CMD_DELTA = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_FINISH
  } back_state_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic [2:0]                 unit;
    logic signed [AMOUNT_W-1:0] amount;
    logic signed [GSEC_W-1:0]   gsec;
    logic [MICRO_W-1:0]         gmicro;
  } item_t;

  // classified command with the converted amount
  typedef struct packed {
    cmd_t                     cmd;
    logic [SEC_W-1:0]         ds;
    logic [MICRO_W-1:0]       dus;
    logic signed [GSEC_W-1:0] gsec;
    logic [MICRO_W-1:0]       gmicro;
  } entry_t;

  typedef struct packed {
    logic [SEC_W-1:0]   seconds;
    logic [MICRO_W-1:0] micro;
    logic               is_valid;
    logic [DELTA_W-1:0] delta;
    logic               fault;
  } result_t;

endpackage

// ----- hdl/tuacc_front.sv -----
`timescale 1ns / 1ps
module tuacc_front import tuacc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  item_t  in_item,
  output logic   push,
  input  logic   full,
  output entry_t push_entry
);

  logic v1, v2, v3, v4;
  item_t item1, item2, item3, item4;
  logic [32:0] uoff2, uoff3;
  logic signed [58:0] prod2;
  logic [48:0] sprod3, sprod4;
  logic [22:0] q0_3, q4;
  logic [33:0] qd3;
  logic [MICRO_W-1:0] r4;

  logic en;
  logic [33:0] amt_ext, uoff_sum, mul_a;
  logic [32:0] off1;
  logic [23:0] mul_b;
  logic signed [58:0] prod1;
  logic is_div1;
  logic [22:0] q0_2;
  logic [MICRO_W-1:0] div2, div3;
  logic [42:0] qd_full;
  logic [33:0] r0;
  logic [63:0] sec64;
  logic [MICRO_W-1:0] us4;

  // the whole pipe advances together unless the last stage is blocked
  assign en       = !v4 || !full;
  assign in_ready = en;
  assign push     = v4 && !full;

  // stage 1: offset and one shared multiplier
  always_comb begin
    amt_ext  = {{2{item1.amount[AMOUNT_W-1]}}, item1.amount};
    is_div1  = (item1.unit == UNIT_USEC) || (item1.unit == UNIT_MSEC);
    off1     = (item1.unit == UNIT_MSEC) ? OFF_MSEC : OFF_USEC;
    uoff_sum = amt_ext + {1'b0, off1};
    case (item1.unit)
      UNIT_USEC: mul_b = RECIP_USEC;
      UNIT_MSEC: mul_b = RECIP_MSEC;
      UNIT_SEC:  mul_b = SEC_PER_SEC;
      UNIT_MIN:  mul_b = SEC_PER_MIN;
      UNIT_HOUR: mul_b = SEC_PER_HOUR;
      UNIT_DAY:  mul_b = SEC_PER_DAY;
      default:   mul_b = '0;
    endcase
    mul_a = is_div1 ? {1'b0, uoff_sum[32:0]} : amt_ext;
    prod1 = $signed(mul_a) * $signed({1'b0, mul_b});
  end

  // stage 2: estimated quotient times divisor
  always_comb begin
    q0_2    = prod2[RECIP_SHIFT+22:RECIP_SHIFT];
    div2    = (item2.unit == UNIT_MSEC) ? USEC_PER_MSEC : USEC_PER_SEC;
    qd_full = 43'(q0_2) * 43'(div2);
  end

  // stage 3: remainder and one correction step
  always_comb begin
    div3 = (item3.unit == UNIT_MSEC) ? USEC_PER_MSEC : USEC_PER_SEC;
    r0   = {1'b0, uoff3} - qd3;
  end

  // stage 4: remove the offset and scale to seconds and microseconds
  always_comb begin
    case (item4.unit)
      UNIT_USEC: begin
        sec64 = 64'(q4) - 64'(K_USEC);
        us4   = r4;
      end
      UNIT_MSEC: begin
        sec64 = 64'(q4) - 64'(K_MSEC);
        us4   = 20'(r4[9:0]) * USEC_PER_MSEC;
      end
      UNIT_SEC, UNIT_MIN, UNIT_HOUR, UNIT_DAY: begin
        sec64 = 64'($signed(sprod4));
        us4   = '0;
      end
      default: begin
        sec64 = '0;
        us4   = '0;
      end
    endcase
    push_entry.cmd    = item4.cmd;
    push_entry.ds     = sec64[SEC_W-1:0];
    push_entry.dus    = us4;
    push_entry.gsec   = item4.gsec;
    push_entry.gmicro = item4.gmicro;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item1  <= in_item;
      item2  <= item1;
      uoff2  <= uoff_sum[32:0];
      prod2  <= prod1;
      item3  <= item2;
      uoff3  <= uoff2;
      sprod3 <= prod2[48:0];
      q0_3   <= q0_2;
      qd3    <= qd_full[33:0];
      item4  <= item3;
      sprod4 <= sprod3;
      if (r0 >= 34'(div3)) begin
        q4 <= q0_3 + 23'd1;
        r4 <= MICRO_W'(r0 - 34'(div3));
      end else begin
        q4 <= q0_3;
        r4 <= r0[MICRO_W-1:0];
      end
    end
  end

endmodule

// ----- hdl/tuacc_fifo.sv -----
`timescale 1ns / 1ps
module tuacc_fifo import tuacc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output entry_t rdata,
  output logic   empty
);

  entry_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_AW:0] count;

  assign full  = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

// ----- hdl/tuacc_back.sv -----
`timescale 1ns / 1ps
module tuacc_back import tuacc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fifo_empty,
  output logic    pop,
  input  entry_t  head,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  back_state_t state, state_next;
  entry_t ent;
  logic [SEC_W-1:0] tsec;
  logic [MICRO_W-1:0] tmicro;
  logic tvalid;
  logic [DELTA_W-1:0] diff, acc, delta_r;
  logic [MICRO_W:0] udiff;
  logic [51:0] plo;
  logic [31:0] phi;
  logic res_valid;
  result_t res;

  logic out_free, commit;
  logic [63:0] gs64, cur64, load_s64;
  logic [MICRO_W:0] sum_us, dif_us;
  logic carry, borrow;
  logic [SEC_W-1:0] ns;
  logic [MICRO_W-1:0] nm;
  logic nvalid;
  logic [31:0] mul_in;
  logic [51:0] mul_out;

  assign out_free   = !res_valid || out_ready;
  assign out_valid  = res_valid;
  assign out_result = res;

  assign mul_in  = (state == ST_MUL_LO) ? diff[31:0] : diff[63:32];
  assign mul_out = 52'(mul_in) * 52'(USEC_PER_SEC);

  // next stored time for load, add and subtract
  always_comb begin
    gs64     = 64'($signed(ent.gsec));
    cur64    = 64'($signed(tsec));
    load_s64 = gs64;
    sum_us   = {1'b0, tmicro} + {1'b0, ent.dus};
    dif_us   = {1'b0, tmicro} - {1'b0, ent.dus};
    carry    = sum_us >= (MICRO_W + 1)'(USEC_PER_SEC);
    borrow   = dif_us[MICRO_W];
    ns       = tsec;
    nm       = tmicro;
    nvalid   = tvalid;
    unique case (ent.cmd)
      CMD_LOAD: begin
        nvalid = 1'b1;
        if (ent.gmicro >= USEC_PER_SEC) begin
          load_s64 = gs64 + 64'd1;
          nm       = ent.gmicro - USEC_PER_SEC;
        end else begin
          nm = ent.gmicro;
        end
        ns = load_s64[SEC_W-1:0];
      end
      CMD_ADD: begin
        if (tvalid) begin
          ns = tsec + ent.ds + SEC_W'(carry);
          nm = carry ? MICRO_W'(sum_us - (MICRO_W + 1)'(USEC_PER_SEC))
                     : sum_us[MICRO_W-1:0];
        end
      end
      CMD_SUB: begin
        if (tvalid) begin
          ns = tsec - ent.ds - SEC_W'(borrow);
          nm = borrow ? MICRO_W'(dif_us + (MICRO_W + 1)'(USEC_PER_SEC))
                      : dif_us[MICRO_W-1:0];
        end
      end
      CMD_DELTA: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    commit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!fifo_empty) begin
          pop        = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (ent.cmd == CMD_DELTA && tvalid) begin
          state_next = ST_MUL_LO;
        end else if (out_free) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_SUM;
      ST_SUM:    state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      tsec      <= '0;
      tmicro    <= '0;
      tvalid    <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= commit || (res_valid && !out_ready);
      if (commit && state == ST_EXEC) begin
        tsec   <= ns;
        tmicro <= nm;
        tvalid <= nvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) ent <= head;
    // delta: (end_s - cur_s) * 1e6 + (end_us - cur_us), modulo 2^64
    if (state == ST_EXEC) begin
      diff  <= gs64 - cur64;
      udiff <= {1'b0, ent.gmicro} - {1'b0, tmicro};
    end
    if (state == ST_MUL_LO) plo <= mul_out;
    if (state == ST_MUL_HI) begin
      phi <= mul_out[31:0];
      acc <= 64'($signed(udiff)) + 64'(plo);
    end
    if (state == ST_SUM) delta_r <= acc + {phi, 32'b0};
    if (commit) begin
      if (state == ST_EXEC) begin
        res.seconds  <= ns;
        res.micro    <= nm;
        res.is_valid <= nvalid;
        res.delta    <= '0;
        res.fault    <= (ent.cmd == CMD_DELTA) && !tvalid;
      end else begin
        res.seconds  <= tsec;
        res.micro    <= tmicro;
        res.is_valid <= tvalid;
        res.delta    <= delta_r;
        res.fault    <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/timestamp_unit_accumulator_core.sv -----
`timescale 1ns / 1ps
// channel   direction  tdata (low bit up)                             tuser (low bit up)
// s_axis    in         amount[31:0], given_seconds[51:0],             command[1:0], unit[2:0]
//                      given_micro[19:0]
// m_axis    out        now_seconds, now_micro[19:0], delta_micro[63:0] is_valid, fault
//
// The front converts the amount in a four-stage pipeline and takes one transfer per cycle
// until its four-entry queue fills. The back sequencer sets the sustained rate, lower for
// a delta on a valid time than for load, add, subtract and a faulting delta, as its
// seconds difference goes through one shared 32x20 multiplier in two halves. Synchronous
// reset clears the stored time, the valid flag, the queue and all pipeline valids. A
// stalled m_axis holds one result in the output register while the back works on the next.
module timestamp_unit_accumulator_core import tuacc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // amount, given_seconds, given_micro
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command, unit
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // now_seconds, now_micro, delta_micro
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // is_valid, fault
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  item_t   in_item;
  entry_t  push_entry, head;
  logic    push, full, pop, fifo_empty;
  result_t res;

  always_comb begin
    in_item.cmd    = cmd_t'(s_axis_tuser[1:0]);
    in_item.unit   = s_axis_tuser[4:2];
    in_item.amount = s_axis_tdata[AMOUNT_W-1:0];
    in_item.gsec   = s_axis_tdata[AMOUNT_W+GSEC_W-1:AMOUNT_W];
    in_item.gmicro = s_axis_tdata[IN_FIELD_W-1:AMOUNT_W+GSEC_W];
  end

  tuacc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .push       (push),
    .full       (full),
    .push_entry (push_entry)
  );

  tuacc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_entry),
    .full  (full),
    .pop   (pop),
    .rdata (head),
    .empty (fifo_empty)
  );

  tuacc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .head       (head),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (res)
  );

  assign m_axis_tdata = OUT_DATA_W'({res.delta, res.micro, res.seconds});
  assign m_axis_tuser = {res.fault, res.is_valid};

endmodule

// ----- test/tb_timestamp_unit_accumulator_core.sv -----
`timescale 1ns / 1ps
module tb_timestamp_unit_accumulator_core;
  import tuacc_pkg::*;

  localparam longint USEC = 1000000;
  localparam logic [GSEC_W-1:0] SEC_TOP    = {1'b0, {(GSEC_W-1){1'b1}}};
  localparam logic [GSEC_W-1:0] SEC_BOTTOM = {1'b1, {(GSEC_W-1){1'b0}}};
  localparam int RANDOM_COMMANDS = 1150;

  // Tracks the stored time and lists the reports the block owes, oldest first.
  class timestamp_tracker;
    logic [SEC_W-1:0]   held_sec;
    logic [MICRO_W-1:0] held_micro;
    logic               held_valid;
    result_t            pending[$];
    int unsigned        mismatches;
    int unsigned        reports_seen;
    int unsigned        faults_seen;
    int unsigned        cmd_count[4];

    function new();
      held_sec = '0;
      held_micro = '0;
      held_valid = 1'b0;
      mismatches = 0;
      reports_seen = 0;
      faults_seen = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
    endfunction

    function void accept_command(cmd_t cmd, logic [AMOUNT_W-1:0] amount, logic [2:0] unit,
                                 logic [GSEC_W-1:0] gsec, logic [MICRO_W-1:0] gmicro);
      longint a, q, r, sec_part, us_part, s, us, g, cur, endv, curv;
      result_t want;
      want = '0;
      a = $signed(amount);
      g = $signed(gsec);
      cmd_count[cmd]++;
      case (cmd)
        CMD_LOAD: begin
          s = g;
          us = gmicro;
          // one carry folds an oversized microsecond count into the seconds
          if (us >= USEC) begin
            us -= USEC;
            s += 1;
          end
          held_sec = s[SEC_W-1:0];
          held_micro = us[MICRO_W-1:0];
          held_valid = 1'b1;
        end
        CMD_ADD, CMD_SUB: begin
          if (held_valid) begin
            sec_part = 0;
            us_part = 0;
            case (unit)
              UNIT_USEC: begin
                q = a / USEC;
                r = a - q * USEC;
                if (r < 0) begin
                  r += USEC;
                  q--;
                end
                sec_part = q;
                us_part = r;
              end
              UNIT_MSEC: begin
                q = a / 1000;
                r = a - q * 1000;
                if (r < 0) begin
                  r += 1000;
                  q--;
                end
                sec_part = q;
                us_part = r * 1000;
              end
              UNIT_SEC:  sec_part = a;
              UNIT_MIN:  sec_part = a * 60;
              UNIT_HOUR: sec_part = a * 3600;
              UNIT_DAY:  sec_part = a * 86400;
              default: ;
            endcase
            s = held_sec;
            us = held_micro;
            if (cmd == CMD_ADD) begin
              s = s + sec_part;
              us = us + us_part;
              if (us >= USEC) begin
                us -= USEC;
                s += 1;
              end
            end else begin
              s = s - sec_part;
              us = us - us_part;
              if (us < 0) begin
                us += USEC;
                s -= 1;
              end
            end
            held_sec = s[SEC_W-1:0];
            held_micro = us[MICRO_W-1:0];
          end
        end
        default: begin
          if (held_valid) begin
            cur = $signed(held_sec);
            endv = g * USEC;
            endv = endv + longint'(gmicro);
            curv = cur * USEC;
            curv = curv + longint'(held_micro);
            want.delta = endv - curv;
          end else begin
            want.fault = 1'b1;
          end
        end
      endcase
      want.seconds = held_sec;
      want.micro = held_micro;
      want.is_valid = held_valid;
      pending.push_back(want);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      result_t want;
      reports_seen++;
      if (pending.size() == 0) begin
        $error("report with nothing outstanding: tdata %h tuser %b", data, user);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (user[1]) faults_seen++;
      compare_field("now_seconds", 64'(want.seconds), 64'(data[SEC_W-1:0]));
      compare_field("now_micro", 64'(want.micro), 64'(data[SEC_W +: MICRO_W]));
      compare_field("delta_micro", want.delta, data[SEC_W+MICRO_W +: DELTA_W]);
      compare_field("is_valid", 64'(want.is_valid), 64'(user[0]));
      compare_field("fault", 64'(want.fault), 64'(user[1]));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // amount, given_seconds, given_micro
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // command, unit
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // now_seconds, now_micro, delta_micro
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // is_valid, fault
  logic [OUT_USER_W-1:0] m_axis_tuser;

  timestamp_tracker tracker = new();
  int burst_left = 0;

  timestamp_unit_accumulator_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAIL timestamp_unit_accumulator_core");
    $finish;
  end

  // Sample mid-cycle: a transfer seen here completes at the next rising edge.
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_report(m_axis_tdata, m_axis_tuser);
  end

  // Receiver: segments of always ready, coin flips, long stalls, rare stalls.
  initial begin
    int mode, seg_len, hold;
    logic rdy;
    forever begin
      mode = $urandom_range(0, 3);
      seg_len = $urandom_range(20, 150);
      hold = 0;
      rdy = 1'b1;
      repeat (seg_len) begin
        @(posedge clk);
        case (mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: begin
            if (hold == 0) begin
              rdy = !rdy;
              hold = rdy ? $urandom_range(1, 3) : $urandom_range(1, 12);
            end
            hold--;
          end
          default: rdy = ($urandom_range(0, 9) != 0);
        endcase
        m_axis_tready <= rdy;
      end
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [AMOUNT_W-1:0] amount,
                           input logic [2:0] unit, input logic [GSEC_W-1:0] gsec,
                           input logic [MICRO_W-1:0] gmicro);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {gmicro, gsec, amount};
    s_axis_tuser <= {unit, cmd};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    tracker.accept_command(cmd, amount, unit, gsec, gmicro);
  endtask

  initial begin
    int pick, v, offset, scale;
    cmd_t cmd;
    logic [AMOUNT_W-1:0] amt;
    logic [2:0] unit;
    logic [GSEC_W-1:0] gsec;
    logic [MICRO_W-1:0] gmic;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // time not loaded yet: add and subtract do nothing, delta faults
    send_item(CMD_DELTA, 32'd0, UNIT_USEC, 52'd5, 20'd7);
    send_item(CMD_ADD, 32'd1000, UNIT_SEC, '0, '0);
    send_item(CMD_SUB, -32'sd1, UNIT_DAY, '0, '0);
    // seconds wrap at the top and back
    send_item(CMD_LOAD, '0, UNIT_USEC, SEC_TOP, 20'd999999);
    send_item(CMD_ADD, 32'd1, UNIT_USEC, '0, '0);
    send_item(CMD_SUB, 32'd1, UNIT_USEC, '0, '0);
    send_item(CMD_DELTA, '0, UNIT_USEC, SEC_BOTTOM, 20'd0);
    // load with microseconds out of range
    send_item(CMD_LOAD, '0, UNIT_USEC, 52'd0, 20'hFFFFF);
    // exact negative multiples and amount extremes in every unit
    send_item(CMD_ADD, -32'sd1000000, UNIT_USEC, '0, '0);
    send_item(CMD_ADD, 32'h8000_0000, UNIT_USEC, '0, '0);
    send_item(CMD_SUB, 32'h7FFF_FFFF, UNIT_USEC, '0, '0);
    send_item(CMD_ADD, -32'sd1000, UNIT_MSEC, '0, '0);
    send_item(CMD_ADD, 32'h8000_0000, UNIT_MSEC, '0, '0);
    send_item(CMD_SUB, 32'h7FFF_FFFF, UNIT_MSEC, '0, '0);
    send_item(CMD_ADD, 32'h8000_0000, UNIT_SEC, '0, '0);
    send_item(CMD_SUB, 32'h8000_0000, UNIT_MIN, '0, '0);
    send_item(CMD_ADD, 32'h7FFF_FFFF, UNIT_HOUR, '0, '0);
    send_item(CMD_SUB, 32'h8000_0000, UNIT_DAY, '0, '0);
    // unused unit codes convert to zero
    send_item(CMD_ADD, 32'd12345, 3'd6, '0, '0);
    send_item(CMD_SUB, -32'sd1, 3'd7, '0, '0);
    // end microseconds above range go into the difference as given
    send_item(CMD_DELTA, '0, UNIT_USEC, SEC_TOP, 20'hFFFFF);
    send_item(CMD_LOAD, '0, UNIT_USEC, SEC_BOTTOM, 20'd0);
    send_item(CMD_SUB, 32'd1, UNIT_USEC, '0, '0);
    send_item(CMD_DELTA, '0, UNIT_USEC, 52'd0, 20'd0);

    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) cmd = CMD_LOAD;
      else if (pick < 45) cmd = CMD_ADD;
      else if (pick < 78) cmd = CMD_SUB;
      else cmd = CMD_DELTA;
      unit = 3'($urandom_range(0, 7));

      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          v = int'($urandom_range(0, 4000)) - 2000;
          amt = v;
        end
        4, 5, 6: amt = $urandom();
        7: begin
          scale = $urandom_range(0, 1) ? 1000 : 1000000;
          amt = -(int'($urandom_range(1, 2000)) * scale);
        end
        8: begin
          case ($urandom_range(0, 4))
            0: amt = 32'h8000_0000;
            1: amt = 32'h7FFF_FFFF;
            2: amt = '0;
            3: amt = '1;
            default: amt = 32'd1;
          endcase
        end
        default: amt = {1'b1, 31'($urandom())};
      endcase

      offset = int'($urandom_range(0, 10000)) - 5000;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gsec = (cmd == CMD_DELTA) ? tracker.held_sec + 52'(offset)
                                                 : 52'(offset * 20);
        5, 6, 7: gsec = 52'({$urandom(), $urandom()});
        8: gsec = SEC_TOP - 52'($urandom_range(0, 3));
        default: gsec = SEC_BOTTOM + 52'($urandom_range(0, 3));
      endcase

      if ($urandom_range(0, 99) < 85) gmic = 20'($urandom_range(0, 999999));
      else gmic = 20'($urandom_range(0, 20'hFFFFF));

      send_item(cmd, amt, unit, gsec, gmic);
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("%0d commands: %0d load, %0d add, %0d subtract, %0d delta",
             tracker.cmd_count[CMD_LOAD] + tracker.cmd_count[CMD_ADD] +
             tracker.cmd_count[CMD_SUB] + tracker.cmd_count[CMD_DELTA],
             tracker.cmd_count[CMD_LOAD], tracker.cmd_count[CMD_ADD],
             tracker.cmd_count[CMD_SUB], tracker.cmd_count[CMD_DELTA]);
    $display("%0d reports checked, %0d delta faults, %0d mismatches",
             tracker.reports_seen, tracker.faults_seen, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("PASS timestamp_unit_accumulator_core");
    end else begin
      $display("FAIL timestamp_unit_accumulator_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tuacc_pkg.sv
hdl/tuacc_front.sv
hdl/tuacc_fifo.sv
hdl/tuacc_back.sv
hdl/timestamp_unit_accumulator_core.sv
test/tb_timestamp_unit_accumulator_core.sv
